@@ rtl/core/lfu_cache_lru_tiebreak_macros.svh @@
// Assertion macros for the LFU cache block.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

`ifndef SYNTHESIS
`define LFUC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfu cache assertion failed");
`define LFUC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfu cache assertion failed");
`else
`define LFUC_ASSERT_NOW(label, ante, cons)
`define LFUC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/lfuc_pkg.sv @@
// Shared types and constants for the LFU cache block.
// No dependencies; used by the controller, the datapath and the top level.
package lfuc_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPD_WAIT,
    ST_RESPOND
  } lfuc_state_e;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic upd_rd;
    logic decide;
  } lfuc_cmd_t;

  typedef struct packed {
    logic last_idx;
    logic cap_zero;
    logic do_upd;
  } lfuc_sts_t;

endpackage

@@ rtl/core/lfu_cache_lru_tiebreak.sv @@
// Top level of the LFU key-value cache with least-recently-used tie break.
// Depends on lfuc_pkg, lfuc_ctrl, lfuc_dp and lfu_cache_lru_tiebreak_macros.svh.
//
// Usage: an operation beat is taken on a rising edge with start high and busy
// low; mode_i selects get (0) or put (1) on lookup_key_i and store_value_i.
// Exactly one result beat follows: hit_o and read_value_o are valid for the
// single cycle in which result_valid_o is high. The receiver cannot stall, so
// the result must be captured in that cycle.
// Each operation first scans all ENTRIES slots, one memory read per cycle,
// then, if the cache changes, makes a second pass that rewrites the recency
// ranks one slot per cycle. The result follows the scan for a get that misses
// and follows the second pass when an entry is touched or stored; busy falls
// in the cycle after the result, so no new operation is taken before then.
// With capacity zero both passes are skipped.
// The capacity register is written through cfg_valid_i/cfg_ready_o while the
// block is idle. Reset clears all valid bits and sets the capacity to 16.
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_cache_lru_tiebreak #(
  parameter int ENTRIES     = lfuc_pkg::ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode_i,
  input  logic signed [lfuc_pkg::DATA_W-1:0] lookup_key_i,
  input  logic signed [lfuc_pkg::DATA_W-1:0] store_value_i,
  output logic                               result_valid_o,
  output logic                               hit_o,
  output logic signed [lfuc_pkg::DATA_W-1:0] read_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lfuc_pkg::CAP_W-1:0]         cfg_data_i
);
  import lfuc_pkg::*;

  lfuc_cmd_t cmd;
  lfuc_sts_t sts;
  logic      cfg_we;

  assign cfg_ready_o = !busy && !start;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  lfuc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  lfuc_dp #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .lookup_key_i  (lookup_key_i),
    .store_value_i (store_value_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o)
  );

  `LFUC_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `LFUC_ASSERT_NOW(a_result_while_busy, result_valid_o, busy && !cmd.decide)
  `LFUC_ASSERT_NEXT(a_single_result_beat, result_valid_o, !result_valid_o && !busy)
  `LFUC_ASSERT_NOW(a_miss_value, result_valid_o && !hit_o,
                   (read_value_o == '0) || (read_value_o == '1))

endmodule

@@ rtl/core/lfuc_ctrl.sv @@
// Sequencer for the LFU cache: scan pass, decision, rank update pass, response.
// Depends on lfuc_pkg; drives the datapath lfuc_dp through command signals.
module lfuc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lfuc_pkg::lfuc_sts_t sts_i,
  output lfuc_pkg::lfuc_cmd_t cmd_o,
  output logic              busy_o,
  output logic              result_valid_o
);
  import lfuc_pkg::*;

  lfuc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.cap_zero ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.last_idx) begin
          state_d = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.do_upd ? ST_UPDATE : ST_RESPOND;
      end
      ST_UPDATE: begin
        cmd_o.upd_rd = 1'b1;
        if (sts_i.last_idx) begin
          state_d = ST_UPD_WAIT;
        end
      end
      ST_UPD_WAIT: begin
        state_d = ST_RESPOND;
      end
      ST_RESPOND: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/lfuc_dp.sv @@
// Datapath for the LFU cache: entry memories, valid bits, scan accumulators,
// decision registers and the capacity register. Depends on lfuc_pkg.
module lfuc_dp #(
  parameter int ENTRIES     = lfuc_pkg::ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfuc_pkg::lfuc_cmd_t               cmd_i,
  output lfuc_pkg::lfuc_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [lfuc_pkg::CAP_W-1:0]        cfg_data_i,
  input  logic                              mode_i,
  input  logic signed [lfuc_pkg::DATA_W-1:0] lookup_key_i,
  input  logic signed [lfuc_pkg::DATA_W-1:0] store_value_i,
  output logic                              hit_o,
  output logic signed [lfuc_pkg::DATA_W-1:0] read_value_o
);
  import lfuc_pkg::*;

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW  = $clog2(ENTRIES + 1);
  localparam int CPW = (UW > CAP_W) ? UW : CAP_W;
  localparam logic [IW-1:0]  LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [CPW-1:0] ENTRIES_C = CPW'(ENTRIES);

  logic [DATA_W-1:0]      key_mem  [ENTRIES];
  logic [DATA_W-1:0]      val_mem  [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_mem  [ENTRIES];
  logic [IW-1:0]          rank_mem [ENTRIES];

  logic [CAP_W-1:0]       cap_q;
  logic [ENTRIES-1:0]     valid_q;
  logic                   mode_q, cap_zero_q;
  logic [DATA_W-1:0]      key_q, sval_q;
  logic [IW-1:0]          idx_q, pidx_q;
  logic                   proc_q, pscan_q;
  logic [DATA_W-1:0]      rd_key_q, rd_val_q;
  logic [COUNT_WIDTH-1:0] rd_cnt_q;
  logic [IW-1:0]          rd_rank_q;

  logic                   found_q, free_found_q, vic_found_q;
  logic [IW-1:0]          hit_slot_q, hit_rank_q, free_slot_q, vic_slot_q, vic_rank_q;
  logic [DATA_W-1:0]      hit_val_q;
  logic [COUNT_WIDTH-1:0] hit_cnt_q, vic_cnt_q;
  logic [UW-1:0]          used_q;

  logic [IW-1:0]          tgt_q, thr_q;
  logic                   thr_all_q;
  logic [DATA_W-1:0]      new_val_q;
  logic [COUNT_WIDTH-1:0] new_cnt_q;
  logic                   res_hit_q;
  logic [DATA_W-1:0]      res_val_q;

  logic                   p_valid, scan_step, wr_tgt, wr_bump;
  logic [IW-1:0]          wr_rank;
  logic [CPW-1:0]         cap_eff;
  logic                   full, insert, do_upd;
  logic [IW-1:0]          tgt_d;

  assign p_valid   = valid_q[pidx_q];
  assign scan_step = proc_q && pscan_q;
  assign wr_tgt    = proc_q && !pscan_q && (pidx_q == tgt_q);
  assign wr_bump   = proc_q && !pscan_q && !wr_tgt && p_valid &&
                     (thr_all_q || (rd_rank_q < thr_q));
  assign wr_rank   = wr_tgt ? '0 : rd_rank_q + IW'(1);

  assign cap_eff = (CPW'(cap_q) > ENTRIES_C) ? ENTRIES_C : CPW'(cap_q);
  assign full    = CPW'(used_q) >= cap_eff;
  assign insert  = !found_q && mode_q && !cap_zero_q;
  assign do_upd  = found_q || insert;
  assign tgt_d   = found_q ? hit_slot_q : (full ? vic_slot_q : free_slot_q);

  assign sts_o.last_idx = (idx_q == LAST_IDX);
  assign sts_o.cap_zero = (cap_q == '0);
  assign sts_o.do_upd   = do_upd;

  assign hit_o        = res_hit_q;
  assign read_value_o = res_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Entry memories: one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd || cmd_i.upd_rd) begin
      rd_key_q  <= key_mem[idx_q];
      rd_val_q  <= val_mem[idx_q];
      rd_cnt_q  <= cnt_mem[idx_q];
      rd_rank_q <= rank_mem[idx_q];
    end
    if (wr_tgt || wr_bump) begin
      rank_mem[pidx_q] <= wr_rank;
    end
    if (wr_tgt) begin
      key_mem[pidx_q] <= key_q;
      val_mem[pidx_q] <= new_val_q;
      cnt_mem[pidx_q] <= new_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      proc_q  <= 1'b0;
      pscan_q <= 1'b0;
      pidx_q  <= '0;
      valid_q <= '0;
    end else begin
      proc_q  <= cmd_i.scan_rd || cmd_i.upd_rd;
      pscan_q <= cmd_i.scan_rd;
      pidx_q  <= idx_q;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.scan_rd || cmd_i.upd_rd) begin
        idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
      end
      if (cmd_i.decide && do_upd) begin
        valid_q[tgt_d] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode_i;
      key_q      <= lookup_key_i;
      sval_q     <= store_value_i;
      cap_zero_q <= (cap_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
      used_q       <= '0;
    end else if (cmd_i.load) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
      used_q       <= '0;
    end else if (scan_step) begin
      if (p_valid) begin
        used_q <= used_q + UW'(1);
      end
      if (p_valid && (rd_key_q == key_q) && !found_q) begin
        found_q <= 1'b1;
      end
      if (!p_valid && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      if (p_valid) begin
        vic_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_step) begin
      if (p_valid && (rd_key_q == key_q) && !found_q) begin
        hit_slot_q <= pidx_q;
        hit_rank_q <= rd_rank_q;
        hit_val_q  <= rd_val_q;
        hit_cnt_q  <= rd_cnt_q;
      end
      if (!p_valid && !free_found_q) begin
        free_slot_q <= pidx_q;
      end
      // Lowest count wins; on equal counts the larger rank is the less recent entry.
      if (p_valid && (!vic_found_q || (rd_cnt_q < vic_cnt_q) ||
                      ((rd_cnt_q == vic_cnt_q) && (rd_rank_q > vic_rank_q)))) begin
        vic_slot_q <= pidx_q;
        vic_cnt_q  <= rd_cnt_q;
        vic_rank_q <= rd_rank_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      tgt_q     <= tgt_d;
      thr_q     <= found_q ? hit_rank_q : vic_rank_q;
      thr_all_q <= insert && !full;
      if (found_q) begin
        new_cnt_q <= (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + COUNT_WIDTH'(1);
      end else begin
        new_cnt_q <= COUNT_WIDTH'(1);
      end
      new_val_q <= mode_q ? sval_q : hit_val_q;
      res_hit_q <= found_q;
      if (mode_q) begin
        res_val_q <= '0;
      end else begin
        res_val_q <= found_q ? hit_val_q : '1;
      end
    end
  end

endmodule

@@ test/testbench.sv @@
// Self-checking bench for the LFU cache with least-recently-used tie break.
// Needs lfuc_pkg and the lfu_cache_lru_tiebreak RTL; predicts every reply
// from its own model of the slots and compares each reply beat field by field.
module testbench;
  import lfuc_pkg::*;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;
  localparam int unsigned SLOTS = ENTRIES_DEF;
  localparam longint unsigned USE_MAX = (64'd1 << COUNT_WIDTH_DEF) - 1;
  localparam int unsigned SETTLE = 4;
  localparam int unsigned END_WAIT = 2 * SLOTS + 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {REQ_OP, REQ_GAP, REQ_DRAIN, REQ_CFG} req_kind_e;

  typedef struct {
    req_kind_e        kind;
    logic             mode;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [CAP_W-1:0] cap;
    int unsigned      count;
  } cache_req_t;

  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] data;
  } cache_reply_t;

  logic clk;
  logic rst_n = 1'b0;
  logic op_start = 1'b0;
  logic op_mode = OP_GET;
  logic [DATA_W-1:0] op_key = '0;
  logic [DATA_W-1:0] op_value = '0;
  logic cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic busy;
  logic reply_valid;
  logic reply_hit;
  logic [DATA_W-1:0] reply_data;
  logic cfg_ready;

  cache_req_t   op_queue[$];
  cache_reply_t pending_replies[$];
  int unsigned  idle_pct = 10;
  int unsigned  gap_cnt = 0;
  int unsigned  settle_cnt = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  mismatches = 0;

  // Shadow copy of the cache slots and the capacity register.
  logic              slot_valid [SLOTS];
  logic [DATA_W-1:0] slot_key   [SLOTS];
  logic [DATA_W-1:0] slot_data  [SLOTS];
  longint unsigned   slot_uses  [SLOTS];
  int unsigned       slot_age   [SLOTS];
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;

  lfu_cache_lru_tiebreak DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (op_start),
    .busy           (busy),
    .mode_i         (op_mode),
    .lookup_key_i   (op_key),
    .store_value_i  (op_value),
    .result_valid_o (reply_valid),
    .hit_o          (reply_hit),
    .read_value_o   (reply_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("mismatch at %0t: %s, got %h, want %h", $realtime, what, got, want);
  endtask

  // Applies one get or put to the shadow slots and queues the reply it must give.
  task automatic predict_cache_access(input logic mode, input logic [DATA_W-1:0] key,
                                      input logic [DATA_W-1:0] value);
    cache_reply_t reply;
    int hit_slot;
    int free_slot;
    int victim;
    int unsigned used;
    int unsigned eff_cap;
    int unsigned rank;
    reply.hit = 1'b0;
    reply.data = (mode == OP_GET) ? '1 : '0;
    eff_cap = (cap_reg > SLOTS) ? SLOTS : cap_reg;
    hit_slot = -1;
    free_slot = -1;
    victim = -1;
    used = 0;
    if (eff_cap != 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_key[i] == key && hit_slot < 0) hit_slot = i;
      end
      if (hit_slot >= 0) begin
        if (slot_uses[hit_slot] < USE_MAX) slot_uses[hit_slot]++;
        rank = slot_age[hit_slot];
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && i != hit_slot && slot_age[i] < rank) slot_age[i]++;
        end
        slot_age[hit_slot] = 0;
        reply.hit = 1'b1;
        if (mode == OP_GET) begin
          reply.data = slot_data[hit_slot];
        end else begin
          slot_data[hit_slot] = value;
        end
      end else if (mode == OP_PUT) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) used++;
          else if (free_slot < 0) free_slot = i;
        end
        if (used >= eff_cap) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))) begin
              victim = i;
            end
          end
          rank = slot_age[victim];
          slot_valid[victim] = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_age[i] > rank) slot_age[i]--;
          end
          free_slot = victim;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) slot_age[i]++;
        end
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = key;
        slot_data[free_slot] = value;
        slot_uses[free_slot] = 1;
        slot_age[free_slot] = 0;
      end
    end
    pending_replies.push_back(reply);
  endtask

  function automatic void push_op(input logic mode, input logic [DATA_W-1:0] key,
                                  input logic [DATA_W-1:0] value);
    cache_req_t req;
    req.mode = mode;
    req.key = key;
    req.value = value;
    req.cap = '0;
    if ($urandom_range(99, 0) < idle_pct) begin
      req.kind = REQ_GAP;
      req.count = $urandom_range(40, 1);
      op_queue.push_back(req);
    end
    req.kind = REQ_OP;
    req.count = 0;
    op_queue.push_back(req);
  endfunction

  function automatic void push_ctrl(input req_kind_e kind, input logic [CAP_W-1:0] cap);
    cache_req_t req;
    req.kind = kind;
    req.mode = OP_GET;
    req.key = '0;
    req.value = '0;
    req.cap = cap;
    req.count = 0;
    op_queue.push_back(req);
  endfunction

  always @(posedge clk) begin : driver_proc
    cache_req_t nxt;
    logic start_nx;
    logic cfg_nx;
    if (rst_n) begin
      start_nx = op_start;
      cfg_nx = cfg_valid;
      if (op_start && !busy) begin
        predict_cache_access(op_mode, op_key, op_value);
        start_nx = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        cfg_nx = 1'b0;
      end
      if (pending_replies.size() == 0 && !op_start && !busy) settle_cnt++;
      else settle_cnt = 0;
      if (!start_nx && !cfg_nx) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
        end else if (op_queue.size() != 0) begin
          nxt = op_queue[0];
          case (nxt.kind)
            REQ_GAP: begin
              gap_cnt = nxt.count;
              void'(op_queue.pop_front());
            end
            REQ_OP: begin
              op_mode <= nxt.mode;
              op_key <= nxt.key;
              op_value <= nxt.value;
              start_nx = 1'b1;
              void'(op_queue.pop_front());
            end
            REQ_DRAIN: begin
              if (settle_cnt >= SETTLE) void'(op_queue.pop_front());
            end
            REQ_CFG: begin
              if (settle_cnt >= SETTLE) begin
                cfg_data <= nxt.cap;
                cfg_nx = 1'b1;
                void'(op_queue.pop_front());
              end
            end
            default: void'(op_queue.pop_front());
          endcase
        end
      end
      op_start <= start_nx;
      cfg_valid <= cfg_nx;
    end
  end

  always @(posedge clk) begin : monitor_proc
    cache_reply_t want;
    if (rst_n && reply_valid) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply beat with nothing outstanding", reply_data, '0);
      end else begin
        want = pending_replies.pop_front();
        if (reply_hit !== want.hit) begin
          report_mismatch("hit", {{(DATA_W-1){1'b0}}, reply_hit}, {{(DATA_W-1){1'b0}}, want.hit});
        end
        if (reply_data !== want.data) begin
          report_mismatch("read value", reply_data, want.data);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (rst_n) begin
      if ((op_start && !busy) || reply_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[lfu_cache_lru_tiebreak] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus_proc
    int unsigned phase_caps [12] = '{16, 1, 31, 3, 0, 8, 17, 2, 16, 5, 12, 16};
    logic [DATA_W-1:0] key_pool[$];
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    int unsigned eff;
    int unsigned n_ops;

    // Extremes of the key and value, hit, miss and overwrite on an empty cache.
    push_op(OP_GET, 32'h0000_0000, $urandom());
    push_op(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_op(OP_GET, 32'h8000_0000, 32'h0000_0000);
    push_op(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    push_op(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_op(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    // Small capacity: evictions by lowest use count.
    push_ctrl(REQ_CFG, 5'd2);
    push_op(OP_PUT, 32'd5, 32'd11);
    push_op(OP_PUT, 32'd6, 32'd12);
    push_op(OP_PUT, 32'd7, 32'd13);
    push_op(OP_GET, 32'd6, 32'd0);
    // Disabled cache keeps its entries.
    push_ctrl(REQ_CFG, 5'd0);
    push_op(OP_GET, 32'h7FFF_FFFF, 32'd0);
    push_op(OP_PUT, 32'd1, 32'd1);
    // Capacity above the slot count, then lowered below the occupancy with ties.
    push_ctrl(REQ_CFG, 5'd31);
    push_op(OP_GET, 32'h7FFF_FFFF, 32'd0);
    push_op(OP_PUT, 32'd20, $urandom());
    push_op(OP_PUT, 32'd21, $urandom());
    push_op(OP_PUT, 32'd22, $urandom());
    push_ctrl(REQ_CFG, 5'd1);
    push_op(OP_PUT, 32'd23, $urandom());
    push_op(OP_GET, 32'd20, 32'd0);
    push_op(OP_PUT, 32'd24, $urandom());
    push_op(OP_GET, 32'd24, 32'd0);

    foreach (phase_caps[p]) begin
      eff = (phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p];
      n_ops = (eff == 0) ? 25 : 110;
      idle_pct = (p == 8) ? 0 : 10;
      push_ctrl(REQ_CFG, CAP_W'(phase_caps[p]));
      key_pool.delete();
      repeat (eff + $urandom_range(8, 1)) key_pool.push_back($urandom());
      if ($urandom_range(1, 0) == 1) key_pool[0] = 32'h8000_0000;
      else key_pool[0] = 32'h7FFF_FFFF;
      for (int i = 0; i < n_ops; i++) begin
        if (i == n_ops / 2) push_ctrl(REQ_DRAIN, '0);
        if ($urandom_range(99, 0) < 15) begin
          key = $urandom();
        end else begin
          key = key_pool[$urandom_range($urandom_range(key_pool.size() - 1, 0), 0)];
        end
        case ($urandom_range(19, 0))
          0: value = '0;
          1: value = '1;
          2: value = 32'h8000_0000;
          3: value = 32'h7FFF_FFFF;
          default: value = $urandom();
        endcase
        push_op(($urandom_range(99, 0) < 45) ? OP_PUT : OP_GET, key, value);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (op_queue.size() != 0 || op_start || cfg_valid || pending_replies.size() != 0) begin
      @(negedge clk);
    end
    repeat (END_WAIT) @(posedge clk);
    while (pending_replies.size() != 0) begin
      report_mismatch("reply never arrived", '0, pending_replies[0].data);
      void'(pending_replies.pop_front());
    end
    if (mismatches == 0) begin
      $display("[lfu_cache_lru_tiebreak] OK");
    end else begin
      $display("[lfu_cache_lru_tiebreak] ERROR");
    end
    $finish;
  end
endmodule

@@ lfu_cache_lru_tiebreak.f @@
+incdir+rtl/core
rtl/core/lfuc_pkg.sv
rtl/core/lfuc_ctrl.sv
rtl/core/lfuc_dp.sv
rtl/core/lfu_cache_lru_tiebreak.sv
test/testbench.sv
